// ===== rtl/core/wsvt_pkg.sv =====
package wsvt_pkg;

    localparam int HISTORY_DEPTH_DEF = 32;

    localparam int DELTA_W   = 24;
    localparam int STAMP_W   = 32;
    localparam int POS_W     = 48;
    localparam int SPD_W     = 40;
    localparam int WIN_W     = 16;
    localparam int GAIN_W    = 18;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 1;
    localparam int GAIN_FRAC = 16;
    localparam int MS_PER_S  = 1000;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 136;
    localparam int M_TUSER_W = 2;

    localparam logic [WIN_W-1:0]  WINDOW_LIMIT_RST = 16'd150;
    localparam logic [GAIN_W-1:0] GAIN_RST         = 18'd21823;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROJ_GAIN    = 1'b1;

    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta;
        logic [STAMP_W-1:0]        stamp;
    } ring_entry_t;

endpackage

// ===== rtl/core/windowed_swipe_velocity_tracker.sv =====
// a clear goes straight to the result; an accepted push evicts the oldest entry if the
// ring is full, writes, trims entries older than the window, then runs the bit-serial divider
// unless there are fewer than two entries or a zero span; a backward push skips to the speed step
// throughput: one item at a time; the next transfer is taken once the result is registered
// reset: synchronous active-low aresetn empties the ring and zeroes position and sums;
// ring memory contents are not cleared and need no clearing pass
module windowed_swipe_velocity_tracker #(
    parameter int HISTORY_DEPTH = wsvt_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [wsvt_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [wsvt_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [wsvt_pkg::S_TDATA_W-1:0]   s_tdata,  // motion_delta, stamp_ms
    input  logic                             s_tuser,  // req_type
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wsvt_pkg::M_TDATA_W-1:0]   m_tdata,  // position, speed, projected_end
    output logic [wsvt_pkg::M_TUSER_W-1:0]   m_tuser   // accepted, evicted_full
);

    localparam int HEAD_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SLOT_W = HEAD_W + 1;
    localparam int SUM_W  = wsvt_pkg::DELTA_W + $clog2(HISTORY_DEPTH);
    localparam int NUM_W  = SUM_W + 10;
    localparam int DCNT_W = $clog2(NUM_W + 1);
    localparam int HALF_W = wsvt_pkg::SPD_W / 2;
    localparam int MUL_W  = HALF_W + wsvt_pkg::GAIN_W;
    localparam int PROD_W = wsvt_pkg::SPD_W + wsvt_pkg::GAIN_W;
    localparam int PM_W   = PROD_W - wsvt_pkg::GAIN_FRAC;
    localparam int POS_W  = wsvt_pkg::POS_W;
    localparam int SPD_W  = wsvt_pkg::SPD_W;
    localparam int DW     = wsvt_pkg::DELTA_W;
    localparam int SW     = wsvt_pkg::STAMP_W;

    localparam logic [63:0] SPD_MAX = 64'((64'd1 << (SPD_W - 1)) - 64'd1);
    localparam logic [63:0] SPD_NEG = 64'(64'd1 << (SPD_W - 1));
    localparam logic signed [NUM_W-1:0] SCALE = NUM_W'(wsvt_pkg::MS_PER_S);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_WRITE    = 4'd1;
    localparam logic [3:0] S_CHECK    = 4'd2;
    localparam logic [3:0] S_DROP     = 4'd3;
    localparam logic [3:0] S_DROP_USE = 4'd4;
    localparam logic [3:0] S_SPEED    = 4'd5;
    localparam logic [3:0] S_DIV      = 4'd6;
    localparam logic [3:0] S_CLAMP    = 4'd7;
    localparam logic [3:0] S_MUL_LO   = 4'd8;
    localparam logic [3:0] S_MUL_HI   = 4'd9;
    localparam logic [3:0] S_PROJ     = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    wsvt_pkg::ring_entry_t history_ring [HISTORY_DEPTH];
    wsvt_pkg::ring_entry_t rdata_reg;
    logic                  mem_we;
    logic                  mem_re;
    logic [HEAD_W-1:0]     mem_waddr;
    logic [HEAD_W-1:0]     mem_raddr;
    wsvt_pkg::ring_entry_t mem_wdata;

    logic [3:0]                      state_reg, state_next;
    logic [HEAD_W-1:0]               head_reg, head_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic signed [SUM_W-1:0]         wsum_reg, wsum_next;
    logic signed [POS_W-1:0]         pos_reg, pos_next;
    logic [wsvt_pkg::WIN_W-1:0]      window_limit_reg, window_limit_next;
    logic [wsvt_pkg::GAIN_W-1:0]     gain_reg, gain_next;
    logic signed [DW-1:0]            in_delta_reg, in_delta_next;
    logic [SW-1:0]                   in_stamp_reg, in_stamp_next;
    logic [SW-1:0]                   last_stamp_reg, last_stamp_next;
    logic [SW-1:0]                   oldest_stamp_reg, oldest_stamp_next;
    logic                            from_full_reg, from_full_next;
    logic                            accepted_reg, accepted_next;
    logic                            evicted_reg, evicted_next;
    logic [SW-1:0]                   rem_reg, rem_next;
    logic [NUM_W-1:0]                quo_reg, quo_next;
    logic [SW-1:0]                   den_reg, den_next;
    logic                            neg_reg, neg_next;
    logic [DCNT_W-1:0]               div_cnt_reg, div_cnt_next;
    logic [SPD_W-1:0]                mag_reg, mag_next;
    logic signed [SPD_W-1:0]         speed_reg, speed_next;
    logic [PROD_W-1:0]               prod_reg, prod_next;
    logic signed [POS_W-1:0]         proj_reg, proj_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [wsvt_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [wsvt_pkg::M_TUSER_W-1:0]  m_tuser_reg, m_tuser_next;

    logic [HEAD_W-1:0]       head_inc;
    logic [SLOT_W-1:0]       slot_raw;
    logic [HEAD_W-1:0]       tail_slot;
    logic [SW-1:0]           back_diff;
    logic [SW-1:0]           age_diff;
    logic [SW-1:0]           span;
    logic signed [NUM_W-1:0] num;
    logic [SW:0]             div_shift;
    logic [63:0]             quo_wide;
    logic [HALF_W-1:0]       mul_a;
    logic [MUL_W-1:0]        mul_p;
    logic [PM_W-1:0]         proj_mag;
    logic signed [PM_W:0]    proj_s;
    logic signed [POS_W:0]   pos_sum;
    logic signed [POS_W:0]   end_sum;
    logic                    out_load;

    assign head_inc  = (head_reg == HEAD_W'(HISTORY_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign slot_raw  = SLOT_W'(head_reg) + SLOT_W'(count_reg);
    assign tail_slot = (slot_raw >= SLOT_W'(HISTORY_DEPTH))
                       ? HEAD_W'(slot_raw - SLOT_W'(HISTORY_DEPTH)) : slot_raw[HEAD_W-1:0];
    assign back_diff = s_tdata[DW +: SW] - last_stamp_reg;
    assign age_diff  = in_stamp_reg - oldest_stamp_reg;
    assign span      = last_stamp_reg - oldest_stamp_reg;
    assign num       = $signed({{10{wsum_reg[SUM_W-1]}}, wsum_reg}) * SCALE;
    assign div_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign quo_wide  = 64'(quo_reg);
    assign mul_a     = (state_reg == S_MUL_HI) ? mag_reg[SPD_W-1:HALF_W] : mag_reg[HALF_W-1:0];
    assign mul_p     = MUL_W'(mul_a) * MUL_W'(gain_reg);
    assign proj_mag  = prod_reg[PROD_W-1:wsvt_pkg::GAIN_FRAC];
    assign proj_s    = neg_reg ? -$signed({1'b0, proj_mag}) : $signed({1'b0, proj_mag});
    assign pos_sum   = {pos_reg[POS_W-1], pos_reg}
                       + {{(POS_W + 1 - DW){in_delta_reg[DW-1]}}, in_delta_reg};
    assign end_sum   = {pos_reg[POS_W-1], pos_reg}
                       + {{(POS_W - PM_W){proj_s[PM_W]}}, proj_s};
    assign out_load  = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next        = state_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        wsum_next         = wsum_reg;
        pos_next          = pos_reg;
        window_limit_next = window_limit_reg;
        gain_next         = gain_reg;
        in_delta_next     = in_delta_reg;
        in_stamp_next     = in_stamp_reg;
        last_stamp_next   = last_stamp_reg;
        oldest_stamp_next = oldest_stamp_reg;
        from_full_next    = from_full_reg;
        accepted_next     = accepted_reg;
        evicted_next      = evicted_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        den_next          = den_reg;
        neg_next          = neg_reg;
        div_cnt_next      = div_cnt_reg;
        mag_next          = mag_reg;
        speed_next        = speed_reg;
        prod_next         = prod_reg;
        proj_next         = proj_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_waddr         = tail_slot;
        mem_raddr         = head_inc;
        mem_wdata         = '{delta: in_delta_reg, stamp: in_stamp_reg};

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                wsvt_pkg::CFG_WINDOW_LIMIT: window_limit_next = cfg_wdata[wsvt_pkg::WIN_W-1:0];
                wsvt_pkg::CFG_PROJ_GAIN:    gain_next = cfg_wdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    in_delta_next = $signed(s_tdata[DW-1:0]);
                    in_stamp_next = s_tdata[DW +: SW];
                    accepted_next = 1'b0;
                    evicted_next  = 1'b0;
                    if (s_tuser == wsvt_pkg::REQ_CLEAR) begin
                        head_next  = '0;
                        count_next = '0;
                        wsum_next  = '0;
                        pos_next   = '0;
                        speed_next = '0;
                        proj_next  = '0;
                        state_next = S_DONE;
                    end else if (count_reg == '0 || !back_diff[SW-1]) begin
                        accepted_next = 1'b1;
                        if (count_reg == CNT_W'(HISTORY_DEPTH)) begin
                            evicted_next   = 1'b1;
                            from_full_next = 1'b1;
                            state_next     = S_DROP;
                        end else begin
                            state_next = S_WRITE;
                        end
                    end else begin
                        state_next = S_SPEED;
                    end
                end
            end
            S_WRITE: begin
                mem_we          = 1'b1;
                last_stamp_next = in_stamp_reg;
                if (count_reg != '0) begin
                    wsum_next = wsum_reg
                                + {{(SUM_W - DW){in_delta_reg[DW-1]}}, in_delta_reg};
                end else begin
                    oldest_stamp_next = in_stamp_reg;
                end
                count_next = count_reg + 1'b1;
                if (pos_sum[POS_W] != pos_sum[POS_W-1]) begin
                    pos_next = pos_sum[POS_W] ? {1'b1, {(POS_W - 1){1'b0}}}
                                              : {1'b0, {(POS_W - 1){1'b1}}};
                end else begin
                    pos_next = pos_sum[POS_W-1:0];
                end
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (count_reg != '0 && !age_diff[SW-1]
                        && age_diff > SW'(window_limit_reg)) begin
                    from_full_next = 1'b0;
                    state_next     = S_DROP;
                end else begin
                    state_next = S_SPEED;
                end
            end
            S_DROP: begin
                mem_re     = 1'b1;
                head_next  = head_inc;
                count_next = count_reg - 1'b1;
                state_next = S_DROP_USE;
            end
            S_DROP_USE: begin
                oldest_stamp_next = rdata_reg.stamp;
                if (count_reg <= CNT_W'(1)) begin
                    wsum_next = '0;
                end else begin
                    wsum_next = wsum_reg
                                - {{(SUM_W - DW){rdata_reg.delta[DW-1]}}, rdata_reg.delta};
                end
                state_next = from_full_reg ? S_WRITE : S_CHECK;
            end
            S_SPEED: begin
                if (count_reg < CNT_W'(2) || span == '0) begin
                    mag_next   = '0;
                    neg_next   = 1'b0;
                    speed_next = '0;
                    state_next = S_MUL_LO;
                end else begin
                    quo_next     = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                    den_next     = span[SW-1] ? -span : span;
                    neg_next     = num[NUM_W-1] ^ span[SW-1];
                    rem_next     = '0;
                    div_cnt_next = DCNT_W'(NUM_W);
                    state_next   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_shift >= {1'b0, den_reg}) begin
                    rem_next = SW'(div_shift - {1'b0, den_reg});
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_next = div_shift[SW-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == DCNT_W'(1)) begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP: begin
                if (!neg_reg && quo_wide > SPD_MAX) begin
                    mag_next = SPD_MAX[SPD_W-1:0];
                end else if (neg_reg && quo_wide > SPD_NEG) begin
                    mag_next = SPD_NEG[SPD_W-1:0];
                end else begin
                    mag_next = quo_wide[SPD_W-1:0];
                end
                speed_next = neg_reg ? -$signed(mag_next) : $signed(mag_next);
                state_next = S_MUL_LO;
            end
            S_MUL_LO: begin
                prod_next  = PROD_W'(mul_p);
                state_next = S_MUL_HI;
            end
            S_MUL_HI: begin
                prod_next  = prod_reg + (PROD_W'(mul_p) << HALF_W);
                state_next = S_PROJ;
            end
            S_PROJ: begin
                if (end_sum[POS_W] != end_sum[POS_W-1]) begin
                    proj_next = end_sum[POS_W] ? {1'b1, {(POS_W - 1){1'b0}}}
                                               : {1'b0, {(POS_W - 1){1'b1}}};
                end else begin
                    proj_next = end_sum[POS_W-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {proj_reg, speed_reg, pos_reg};
            m_tuser_next  = {evicted_reg, accepted_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            history_ring[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= history_ring[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            head_reg         <= '0;
            count_reg        <= '0;
            wsum_reg         <= '0;
            pos_reg          <= '0;
            window_limit_reg <= wsvt_pkg::WINDOW_LIMIT_RST;
            gain_reg         <= wsvt_pkg::GAIN_RST;
            from_full_reg    <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            count_reg        <= count_next;
            wsum_reg         <= wsum_next;
            pos_reg          <= pos_next;
            window_limit_reg <= window_limit_next;
            gain_reg         <= gain_next;
            from_full_reg    <= from_full_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_delta_reg     <= in_delta_next;
        in_stamp_reg     <= in_stamp_next;
        last_stamp_reg   <= last_stamp_next;
        oldest_stamp_reg <= oldest_stamp_next;
        accepted_reg     <= accepted_next;
        evicted_reg      <= evicted_next;
        rem_reg          <= rem_next;
        quo_reg          <= quo_next;
        den_reg          <= den_next;
        neg_reg          <= neg_next;
        div_cnt_reg      <= div_cnt_next;
        mag_reg          <= mag_next;
        speed_reg        <= speed_next;
        prod_reg         <= prod_next;
        proj_reg         <= proj_next;
        m_tdata_reg      <= m_tdata_next;
        m_tuser_reg      <= m_tuser_next;
    end

endmodule

// ===== tb/windowed_swipe_velocity_tracker_tb.sv =====
`timescale 1ns / 100ps

module windowed_swipe_velocity_tracker_tb;
    import wsvt_pkg::*;

    localparam int     RING_DEPTH  = HISTORY_DEPTH_DEF;
    localparam int     IDLE_LIMIT  = 5000;
    localparam int     DRAIN_WAIT  = 200;
    localparam longint POS_HI      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint POS_LO      = -POS_HI - 1;
    localparam longint SPD_HI      = 64'sh0000_007F_FFFF_FFFF;
    localparam longint SPD_LO      = -SPD_HI - 1;

    typedef struct {
        logic              accepted;
        logic              evicted_full;
        logic [POS_W-1:0]  position;
        logic [SPD_W-1:0]  speed;
        logic [POS_W-1:0]  projected_end;
    } motion_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // motion_delta, stamp_ms
    logic                   s_tuser;   // req_type
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // position, speed, projected_end
    logic [M_TUSER_W-1:0]   m_tuser;   // accepted, evicted_full

    windowed_swipe_velocity_tracker #(
        .HISTORY_DEPTH(RING_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // tracker state mirror
    int              ring_delta [RING_DEPTH];
    logic [31:0]     ring_stamp [RING_DEPTH];
    int              ring_head;
    int              ring_fill;
    longint          window_sum;
    longint          position_acc;
    logic [WIN_W-1:0]  window_ms;
    logic [GAIN_W-1:0] proj_gain;
    logic [31:0]     last_stamp;

    motion_result_t  pending_motion[$];
    motion_result_t  want;
    int              fault_count;
    int              idle_cycles;
    int              burst_left;
    int              rx_mode;
    int              rx_mode_left;
    int              rx_hold_left;
    logic            rx_hold_ready;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint stamp_gap(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return longint'($signed(diff));
    endfunction

    task automatic drop_oldest_entry();
        if (ring_fill != 0) begin
            ring_head = (ring_head + 1) % RING_DEPTH;
            ring_fill--;
            if (ring_fill >= 1) window_sum -= ring_delta[ring_head];
            if (ring_fill <= 1) window_sum = 0;
        end
    endtask

    task automatic track_motion(input logic req, input int d, input logic [31:0] stamp);
        motion_result_t r;
        longint spd;
        longint span;
        longint proj;
        r = '{default: '0};
        if (req == REQ_CLEAR) begin
            ring_head    = 0;
            ring_fill    = 0;
            window_sum   = 0;
            position_acc = 0;
        end else begin
            if (ring_fill == 0 ||
                stamp_gap(stamp, ring_stamp[(ring_head + ring_fill - 1) % RING_DEPTH]) >= 0) begin
                r.accepted = 1'b1;
                if (ring_fill >= RING_DEPTH) begin
                    drop_oldest_entry();
                    r.evicted_full = 1'b1;
                end
                ring_delta[(ring_head + ring_fill) % RING_DEPTH] = d;
                ring_stamp[(ring_head + ring_fill) % RING_DEPTH] = stamp;
                if (ring_fill > 0) window_sum += d;
                ring_fill++;
                position_acc = clamp_to(position_acc + d, POS_LO, POS_HI);
                last_stamp = stamp;
                while (ring_fill > 0 &&
                       stamp_gap(stamp, ring_stamp[ring_head]) > longint'(window_ms))
                    drop_oldest_entry();
            end
            spd = 0;
            if (ring_fill >= 2) begin
                span = stamp_gap(ring_stamp[(ring_head + ring_fill - 1) % RING_DEPTH],
                                 ring_stamp[ring_head]);
                if (span != 0)
                    spd = clamp_to((window_sum * MS_PER_S) / span, SPD_LO, SPD_HI);
            end
            proj = (spd * longint'(proj_gain)) / (longint'(1) << GAIN_FRAC);
            proj = clamp_to(position_acc + proj, POS_LO, POS_HI);
            r.position      = position_acc[POS_W-1:0];
            r.speed         = spd[SPD_W-1:0];
            r.projected_end = proj[POS_W-1:0];
        end
        pending_motion.insert(pending_motion.size(), r);
    endtask

    task automatic send_item(input logic req, input logic signed [DELTA_W-1:0] delta,
                             input logic [31:0] stamp);
        int unsigned gap_cycles;
        gap_cycles = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end
        burst_left--;
        if (gap_cycles != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_cycles) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {stamp, delta};
        do @(posedge aclk); while (!s_tready);
        track_motion(req, int'(delta), stamp);
    endtask

    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_motion.size() != 0) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        settle_block();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_WINDOW_LIMIT) window_ms = value[WIN_W-1:0];
        else proj_gain = value[GAIN_W-1:0];
    endtask

    task automatic test_directed();
        // extremes, backward stamp, equal stamp, window trim
        send_item(REQ_PUSH, 24'sh7FFFFF, 32'd1000);
        send_item(REQ_PUSH, 24'sh800000, 32'd1010);
        send_item(REQ_PUSH, 24'sh000100, 32'd1050);
        send_item(REQ_PUSH, -24'sd5, 32'd1049);
        send_item(REQ_PUSH, 24'sd7, 32'd1050);
        send_item(REQ_PUSH, 24'sd300, 32'd1300);
        send_item(REQ_CLEAR, 24'sh7FFFFF, 32'hFFFF_FFFF);
        // zero span
        send_item(REQ_PUSH, 24'sd5, 32'd500);
        send_item(REQ_PUSH, 24'sd9, 32'd500);
        send_item(REQ_PUSH, -24'sd9, 32'd499);
        send_item(REQ_CLEAR, 24'sd0, 32'd0);
        // stamp counter wrap
        send_item(REQ_PUSH, 24'sd1000, 32'hFFFF_FFF0);
        send_item(REQ_PUSH, -24'sd1000, 32'h0000_0005);
        send_item(REQ_PUSH, 24'sd300, 32'h0000_0020);
        send_item(REQ_CLEAR, 24'sd0, 32'd0);
        // span wraps past half the counter
        send_item(REQ_PUSH, 24'sd256, 32'd0);
        send_item(REQ_PUSH, 24'sd512, 32'd100);
        send_item(REQ_PUSH, -24'sd768, 32'h8000_0063);
        send_item(REQ_PUSH, 24'sd1, 32'h8000_0064);
        send_item(REQ_CLEAR, 24'sd0, 32'd0);
    endtask

    task automatic test_full_ring();
        logic signed [DELTA_W-1:0] d;
        write_cfg(CFG_WINDOW_LIMIT, 18'(16'hFFFF));
        write_cfg(CFG_PROJ_GAIN, 18'h3FFFF);
        send_item(REQ_CLEAR, 24'sd0, 32'd0);
        for (int i = 0; i < RING_DEPTH + 8; i++) begin
            d = DELTA_W'($urandom);
            if (i % 7 == 3) d = 24'sh7FFFFF;
            if (i % 7 == 5) d = 24'sh800000;
            send_item(REQ_PUSH, d, 32'd5000 + i);
        end
    endtask

    task automatic test_random_phase(input logic [WIN_W-1:0] win, input logic [GAIN_W-1:0] gain,
                                     input int n_items);
        int unsigned pick;
        int unsigned step;
        logic [31:0] st;
        logic signed [DELTA_W-1:0] d;
        logic req;
        write_cfg(CFG_WINDOW_LIMIT, CFG_W'(win));
        write_cfg(CFG_PROJ_GAIN, gain);
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            d = ($urandom_range(0, 9) < 7) ? DELTA_W'($urandom)
                                           : DELTA_W'($urandom_range(0, 4000) - 2000);
            step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, int'(win) + 20)
                                               : $urandom_range(1, 12);
            req = REQ_PUSH;
            if (pick < 3) begin
                req = REQ_CLEAR;
                st  = $urandom;
            end else if (pick < 9) begin
                st = last_stamp - $urandom_range(1, 1000);
            end else if (pick < 13) begin
                st = $urandom;
            end else if (pick < 20) begin
                st = last_stamp;
            end else begin
                st = last_stamp + step;
            end
            send_item(req, d, st);
        end
    endtask

    task automatic finish_run();
        settle_block();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_motion.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result transfer: tuser %b tdata %h", m_tuser, m_tdata);
            end else begin
                want = pending_motion[0];
                pending_motion.delete(0);
                if (m_tuser[0] !== want.accepted || m_tuser[1] !== want.evicted_full ||
                    m_tdata[47:0] !== want.position || m_tdata[87:48] !== want.speed ||
                    m_tdata[135:88] !== want.projected_end) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display({"mismatch exp/act: accepted %0d/%0d evicted %0d/%0d ",
                                  "pos %0d/%0d speed %0d/%0d proj %0d/%0d"},
                                 want.accepted, m_tuser[0], want.evicted_full, m_tuser[1],
                                 $signed(want.position), $signed(m_tdata[47:0]),
                                 $signed(want.speed), $signed(m_tdata[87:48]),
                                 $signed(want.projected_end), $signed(m_tdata[135:88]));
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(100, 400);
        end
        rx_mode_left--;
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                if (rx_hold_left != 0) begin
                    rx_hold_left--;
                end else begin
                    rx_hold_ready = !rx_hold_ready;
                    rx_hold_left  = rx_hold_ready ? $urandom_range(1, 5) : $urandom_range(1, 30);
                end
                m_tready <= rx_hold_ready;
            end
        endcase
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        fault_count   = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        rx_mode       = 0;
        rx_mode_left  = 0;
        rx_hold_left  = 0;
        rx_hold_ready = 1'b1;
        ring_head     = 0;
        ring_fill     = 0;
        window_sum    = 0;
        position_acc  = 0;
        last_stamp    = '0;
        window_ms     = WINDOW_LIMIT_RST;
        proj_gain     = GAIN_RST;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_full_ring();
        test_random_phase(WINDOW_LIMIT_RST, GAIN_RST, 100);
        test_random_phase(16'd0, 18'd0, 100);
        test_random_phase(16'hFFFF, 18'h3FFFF, 100);
        test_random_phase(WIN_W'($urandom), GAIN_W'($urandom), 100);
        test_random_phase(16'd40, 18'd65536, 100);
        test_random_phase(16'hFFFF, GAIN_W'($urandom), 100);
        finish_run();
    end

endmodule
